// ===== design/mmas_pkg.sv =====
// shared constants, register codes and sequencer states of the masked moving-average smoother
package mmas_pkg;

  localparam int MAX_HALF_WINDOW = 32;
  localparam int MAX_RESULTS     = 34;
  localparam int SMP_W           = 32;
  localparam int HW_W            = 6;
  localparam int LIM_W           = 31;
  localparam int IDX_W           = 16;
  localparam int CFG_IDX_W       = 3;

  // circular sample store: two half windows plus both outer neighbours
  localparam int STORE_DEPTH = 2 * MAX_HALF_WINDOW + 2;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int RD_W        = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int SUM_W       = SMP_W + $clog2(2 * MAX_HALF_WINDOW);
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  localparam logic [HW_W-1:0]  HALF_WINDOW_RST  = HW_W'(10);
  localparam logic [LIM_W-1:0] JUMP_LIMIT_RST   = LIM_W'(10);
  localparam logic [IDX_W-1:0] PROTECT_LOW_RST  = IDX_W'(800);
  localparam logic [IDX_W-1:0] PROTECT_HIGH_RST = IDX_W'(1200);
  localparam logic [LIM_W-1:0] SAT_LEVEL_RST    = LIM_W'(10000000);
  localparam logic [IDX_W-1:0] SAT_START_RST    = IDX_W'(1900);
  localparam logic [IDX_W-1:0] SAMPLE_COUNT_RST = IDX_W'(2016);
  localparam logic [IDX_W-1:0] MIN_SAMPLES      = IDX_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WINDOW  = 3'd0,
    CFG_JUMP_LIMIT   = 3'd1,
    CFG_PROTECT_LOW  = 3'd2,
    CFG_PROTECT_HIGH = 3'd3,
    CFG_SAT_LEVEL    = 3'd4,
    CFG_SAT_START    = 3'd5,
    CFG_SAMPLE_COUNT = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ACC,
    ST_DLOAD,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_e;

endpackage

// ===== design/masked_moving_average_smoother.sv =====
// masked moving-average smoother: sample store, masking walk, serial divider and result sequencer
//
// Samples of one waveform come in one item at a time and are kept in a 66-entry circular
// store. Sample k = p+D releases the average of samples p-D..p+D-1, leaving out jump samples
// outside the protected range and saturated late samples; sample 2D also releases positions
// 0..D-1 and the final sample of the waveform releases positions N-D..N-1 (last set on the
// final one). An item that releases nothing goes from setup straight back to idle. An item
// that releases results is slower: the store has one read port and is walked one sample per
// cycle (2D+2 reads), and the quotient comes from a restoring divider that settles one bit
// per cycle. The next item is taken once the last result has moved into the output register.
// An all-rejected window gives zero with empty_window set. Configuration is taken on any
// cycle and should only be written while no item is in flight.
module masked_moving_average_smoother (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mmas_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mmas_pkg::LIM_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mmas_pkg::SMP_W-1:0]   sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mmas_pkg::SMP_W-1:0]   smoothed_o,
  output logic [mmas_pkg::IDX_W-1:0]          position_o,
  output logic                                empty_window_o,
  output logic                                last_o
);

  localparam int SMP_W = mmas_pkg::SMP_W;
  localparam int HW_W  = mmas_pkg::HW_W;
  localparam int LIM_W = mmas_pkg::LIM_W;
  localparam int IDX_W = mmas_pkg::IDX_W;
  localparam int PTR_W = mmas_pkg::PTR_W;
  localparam int RD_W  = mmas_pkg::RD_W;
  localparam int CNT_W = mmas_pkg::CNT_W;
  localparam int SUM_W = mmas_pkg::SUM_W;
  localparam int DC_W  = mmas_pkg::DIV_CNT_W;

  // configuration registers
  logic [HW_W-1:0]  half_window_q;
  logic [LIM_W-1:0] jump_limit_q;
  logic [IDX_W-1:0] protect_low_q;
  logic [IDX_W-1:0] protect_high_q;
  logic [LIM_W-1:0] sat_level_q;
  logic [IDX_W-1:0] sat_start_q;
  logic [IDX_W-1:0] sample_count_q;

  mmas_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0] in_idx_q;
  logic [PTR_W-1:0] wr_ptr_q;
  logic [IDX_W-1:0] k_q;
  logic [HW_W-1:0]  d_q;
  logic             last_q;
  logic [PTR_W-1:0] base_q;

  logic [SMP_W-1:0] mem [mmas_pkg::STORE_DEPTH];
  logic [PTR_W-1:0] rd_addr_q;
  logic [RD_W-1:0]  rd_cnt_q;
  logic             neg_q;
  logic [SMP_W-1:0] mem_data_q;
  logic             m_vld_q;
  logic [RD_W-1:0]  m_j_q;

  logic [SMP_W-1:0] s_x_q;
  logic             s_step_q;
  logic             s_sat_q;
  logic             s_vld_q;
  logic [RD_W-1:0]  s_j_q;

  logic [SMP_W-1:0] a_x_q;
  logic             a_step_q;
  logic             a_sat_q;
  logic [IDX_W-1:0] idx_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;

  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q;
  logic [DC_W-1:0]  div_cnt_q;
  logic             neg_sum_q;

  logic [SMP_W-1:0] avg_q;
  logic             empty_q;
  logic [IDX_W-1:0] em_pos_q;
  logic [IDX_W-1:0] em_end_q;

  logic             out_vld_q;
  logic [SMP_W-1:0] out_smoothed_q;
  logic [IDX_W-1:0] out_position_q;
  logic             out_empty_q;
  logic             out_last_q;

  // sequencer controls
  logic in_acc;
  logic issue;
  logic emit_load;
  logic acc_done;
  logic div_done;
  logic enough;

  // effective half window and final-sample test at accept time
  logic [IDX_W-1:0] n_eff;
  logic [HW_W-1:0]  d1, d2, d3, d_new;
  logic [IDX_W-1:0] half_n;
  logic [HW_W:0]    span3;
  logic             acc_last;

  always_comb begin
    n_eff    = (sample_count_q < mmas_pkg::MIN_SAMPLES) ? mmas_pkg::MIN_SAMPLES : sample_count_q;
    d1       = (half_window_q == '0) ? HW_W'(1) : half_window_q;
    d2       = (d1 > HW_W'(mmas_pkg::MAX_HALF_WINDOW)) ? HW_W'(mmas_pkg::MAX_HALF_WINDOW) : d1;
    half_n   = (n_eff - IDX_W'(1)) >> 1;
    d3       = (half_n < IDX_W'(d2)) ? half_n[HW_W-1:0] : d2;
    span3    = {d3, 1'b1};
    // a whole-waveform burst larger than the result limit narrows the window by one
    d_new    = ((n_eff == IDX_W'(span3)) &&
                (span3 > (HW_W+1)'(mmas_pkg::MAX_RESULTS))) ? d3 - HW_W'(1) : d3;
    acc_last = (in_idx_q >= (n_eff - IDX_W'(1)));
  end

  // quantities derived from the latched item
  logic [RD_W-1:0]  last_j;
  logic [PTR_W-1:0] span_p;
  logic [PTR_W-1:0] start_addr;
  logic [IDX_W-1:0] two_d;
  logic [IDX_W-1:0] pos_p;

  always_comb begin
    last_j     = RD_W'({d_q, 1'b1});
    span_p     = PTR_W'({d_q, 1'b1});
    start_addr = (base_q >= span_p) ? base_q - span_p
                                    : base_q - span_p + PTR_W'(mmas_pkg::STORE_DEPTH);
    two_d      = IDX_W'({d_q, 1'b0});
    pos_p      = k_q - IDX_W'(d_q);
    enough     = (k_q >= two_d);
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready_o = (state_q == mmas_pkg::ST_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    issue      = (state_q == mmas_pkg::ST_ACC) && (rd_cnt_q <= last_j);
    acc_done   = (state_q == mmas_pkg::ST_ACC) && s_vld_q && (s_j_q == last_j);
    div_done   = (state_q == mmas_pkg::ST_DIV) && (div_cnt_q == DC_W'(SUM_W - 1));
    emit_load  = (state_q == mmas_pkg::ST_EMIT) && (!out_vld_q || out_ready_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmas_pkg::ST_IDLE:  if (in_acc) state_d = mmas_pkg::ST_SETUP;
      mmas_pkg::ST_SETUP: state_d = enough ? mmas_pkg::ST_ACC : mmas_pkg::ST_IDLE;
      mmas_pkg::ST_ACC:   if (acc_done) state_d = mmas_pkg::ST_DLOAD;
      mmas_pkg::ST_DLOAD: state_d = mmas_pkg::ST_DIV;
      mmas_pkg::ST_DIV:   if (div_done) state_d = mmas_pkg::ST_FIX;
      mmas_pkg::ST_FIX:   state_d = mmas_pkg::ST_EMIT;
      mmas_pkg::ST_EMIT:  if (emit_load && (em_pos_q == em_end_q)) state_d = mmas_pkg::ST_IDLE;
      default:            state_d = mmas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q  <= mmas_pkg::HALF_WINDOW_RST;
      jump_limit_q   <= mmas_pkg::JUMP_LIMIT_RST;
      protect_low_q  <= mmas_pkg::PROTECT_LOW_RST;
      protect_high_q <= mmas_pkg::PROTECT_HIGH_RST;
      sat_level_q    <= mmas_pkg::SAT_LEVEL_RST;
      sat_start_q    <= mmas_pkg::SAT_START_RST;
      sample_count_q <= mmas_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mmas_pkg::CFG_HALF_WINDOW:  half_window_q  <= cfg_data_i[HW_W-1:0];
        mmas_pkg::CFG_JUMP_LIMIT:   jump_limit_q   <= cfg_data_i;
        mmas_pkg::CFG_PROTECT_LOW:  protect_low_q  <= cfg_data_i[IDX_W-1:0];
        mmas_pkg::CFG_PROTECT_HIGH: protect_high_q <= cfg_data_i[IDX_W-1:0];
        mmas_pkg::CFG_SAT_LEVEL:    sat_level_q    <= cfg_data_i;
        mmas_pkg::CFG_SAT_START:    sat_start_q    <= cfg_data_i[IDX_W-1:0];
        mmas_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[wr_ptr_q] <= sample_i;
    end
    mem_data_q <= mem[rd_addr_q];
  end

  // input counters and latched item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_idx_q <= '0;
      wr_ptr_q <= '0;
      k_q      <= '0;
      d_q      <= '0;
      last_q   <= 1'b0;
      base_q   <= '0;
    end else if (in_acc) begin
      k_q    <= in_idx_q;
      d_q    <= d_new;
      last_q <= acc_last;
      base_q <= wr_ptr_q;
      if (acc_last) begin
        in_idx_q <= '0;
        wr_ptr_q <= '0;
      end else begin
        in_idx_q <= in_idx_q + IDX_W'(1);
        wr_ptr_q <= (wr_ptr_q == PTR_W'(mmas_pkg::STORE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_q + PTR_W'(1);
      end
    end
  end

  // read walk over the window and its two outer neighbours
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_cnt_q  <= '0;
      neg_q     <= 1'b0;
      m_vld_q   <= 1'b0;
      m_j_q     <= '0;
    end else begin
      m_vld_q <= issue;
      if (state_q == mmas_pkg::ST_SETUP) begin
        rd_addr_q <= start_addr;
        rd_cnt_q  <= '0;
        neg_q     <= (k_q == two_d);
      end else if (issue) begin
        m_j_q     <= rd_cnt_q;
        rd_cnt_q  <= rd_cnt_q + RD_W'(1);
        rd_addr_q <= (rd_addr_q == PTR_W'(mmas_pkg::STORE_DEPTH - 1)) ? '0
                                                                      : rd_addr_q + PTR_W'(1);
      end
    end
  end

  // step stage: one neighbour difference per sample, shared by both neighbours
  logic [SMP_W-1:0] x_cur;
  logic [SMP_W:0]   diff;
  logic [SMP_W:0]   lim_pos;
  logic [SMP_W:0]   lim_neg;
  logic             step_now;
  logic             sat_now;

  always_comb begin
    // the left neighbour of the first sample lies outside the waveform
    x_cur    = ((m_j_q == '0) && neg_q) ? '0 : mem_data_q;
    diff     = {x_cur[SMP_W-1], x_cur} - {s_x_q[SMP_W-1], s_x_q};
    lim_pos  = (SMP_W+1)'(jump_limit_q);
    lim_neg  = '0 - lim_pos;
    step_now = ($signed(diff) > $signed(lim_pos)) || ($signed(diff) < $signed(lim_neg));
    sat_now  = $signed({x_cur[SMP_W-1], x_cur}) > $signed((SMP_W+1)'(sat_level_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_vld_q) begin
      s_x_q    <= x_cur;
      s_step_q <= step_now;
      s_sat_q  <= sat_now;
      s_j_q    <= m_j_q;
    end
  end

  // masking and accumulation of the sample before the newest one
  logic keep;

  always_comb begin
    keep = !(((a_step_q || s_step_q) &&
              !((idx_q >= protect_low_q) && (idx_q <= protect_high_q))) ||
             (a_sat_q && (idx_q > sat_start_q)));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmas_pkg::ST_SETUP) begin
      sum_q <= '0;
      cnt_q <= '0;
      idx_q <= k_q - two_d;
    end else if (s_vld_q) begin
      a_x_q    <= s_x_q;
      a_step_q <= s_step_q;
      a_sat_q  <= s_sat_q;
      if (s_j_q >= RD_W'(2)) begin
        idx_q <= idx_q + IDX_W'(1);
        if (keep) begin
          sum_q <= sum_q + {{(SUM_W-SMP_W){a_x_q[SMP_W-1]}}, a_x_q};
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  logic [CNT_W-1:0] rem_sh;
  logic             rem_ge;

  always_comb begin
    rem_sh = {rem_q[CNT_W-2:0], quo_q[SUM_W-1]};
    rem_ge = (rem_sh >= cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmas_pkg::ST_DLOAD) begin
      quo_q     <= sum_q[SUM_W-1] ? ('0 - sum_q) : sum_q;
      neg_sum_q <= sum_q[SUM_W-1];
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (state_q == mmas_pkg::ST_DIV) begin
      quo_q     <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q     <= rem_ge ? rem_sh - cnt_q : rem_sh;
      div_cnt_q <= div_cnt_q + DC_W'(1);
    end
  end

  // sign fix, empty window, and the run of positions to emit
  always_ff @(posedge clk_i) begin
    if (state_q == mmas_pkg::ST_SETUP) begin
      em_pos_q <= (k_q == two_d) ? '0 : pos_p;
      em_end_q <= last_q ? k_q : pos_p;
    end else if (emit_load) begin
      em_pos_q <= em_pos_q + IDX_W'(1);
    end
    if (state_q == mmas_pkg::ST_FIX) begin
      empty_q <= (cnt_q == '0);
      if (cnt_q == '0) begin
        avg_q <= '0;
      end else if (neg_sum_q) begin
        avg_q <= '0 - quo_q[SMP_W-1:0];
      end else begin
        avg_q <= quo_q[SMP_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_smoothed_q <= avg_q;
      out_position_q <= em_pos_q;
      out_empty_q    <= empty_q;
      out_last_q     <= last_q && (em_pos_q == em_end_q);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign smoothed_o     = out_smoothed_q;
  assign position_o     = out_position_q;
  assign empty_window_o = out_empty_q;
  assign last_o         = out_last_q;

endmodule

// ===== sim/mmas_checker.sv =====
// result checker for the masked moving-average smoother: register mirror, prediction, compare
module mmas_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mmas_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mmas_pkg::LIM_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [mmas_pkg::SMP_W-1:0] sample_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [mmas_pkg::SMP_W-1:0] smoothed_i,
  input  logic [mmas_pkg::IDX_W-1:0]       position_i,
  input  logic                             empty_window_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SMP_W       = mmas_pkg::SMP_W;
  localparam int IDX_W       = mmas_pkg::IDX_W;
  localparam int HW_W        = mmas_pkg::HW_W;
  localparam int LIM_W       = mmas_pkg::LIM_W;
  localparam int STORE_DEPTH = mmas_pkg::STORE_DEPTH;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [SMP_W-1:0] smoothed;
    logic [IDX_W-1:0]        position;
    logic                    empty_window;
    logic                    is_last;
  } smooth_result_t;

  logic [HW_W-1:0]         half_window;
  logic [LIM_W-1:0]        jump_limit;
  logic [LIM_W-1:0]        sat_level;
  logic [IDX_W-1:0]        protect_low;
  logic [IDX_W-1:0]        protect_high;
  logic [IDX_W-1:0]        sat_start;
  logic [IDX_W-1:0]        sample_count;
  logic signed [SMP_W-1:0] sample_store [STORE_DEPTH];
  logic [IDX_W-1:0]        sample_idx;
  smooth_result_t          expected_results [$];
  int                      mismatches;

  // indices before the waveform start read as zero
  function automatic longint stored_sample(input int idx);
    if (idx < 0) return 0;
    return longint'(sample_store[idx % STORE_DEPTH]);
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void add_expected(input smooth_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic logic signed [SMP_W-1:0] window_mean(input int p, input int d,
                                                          output logic none_kept);
    longint sum;
    longint v;
    longint lim;
    int     kept;
    int     i;
    logic   jump;
    logic   prot;
    logic   sat;
    sum  = 0;
    kept = 0;
    lim  = longint'(jump_limit);
    for (i = p - d; i < p + d; i++) begin
      v    = stored_sample(i);
      jump = magnitude(v - stored_sample(i - 1)) > lim ||
             magnitude(v - stored_sample(i + 1)) > lim;
      prot = i >= int'(protect_low) && i <= int'(protect_high);
      sat  = v > longint'(sat_level) && i > int'(sat_start);
      if (!((jump && !prot) || sat)) begin
        sum += v;
        kept++;
      end
    end
    none_kept = (kept == 0);
    return (kept == 0) ? '0 : SMP_W'(sum / kept);
  endfunction

  function automatic void release_results(input logic signed [SMP_W-1:0] s);
    int                      n_eff;
    int                      d;
    int                      k;
    int                      p;
    int                      q;
    logic                    fin;
    logic                    none_kept;
    logic signed [SMP_W-1:0] mean;
    n_eff = (sample_count < mmas_pkg::MIN_SAMPLES) ? int'(mmas_pkg::MIN_SAMPLES)
                                                   : int'(sample_count);
    d = (half_window == '0) ? 1 : int'(half_window);
    if (d > mmas_pkg::MAX_HALF_WINDOW) d = mmas_pkg::MAX_HALF_WINDOW;
    if (d > (n_eff - 1) / 2) d = (n_eff - 1) / 2;
    // a waveform of exactly one window would burst too many results at once
    if (n_eff == 2 * d + 1 && 2 * d + 1 > mmas_pkg::MAX_RESULTS) d--;
    k = int'(sample_idx);
    sample_store[k % STORE_DEPTH] = s;
    fin = (k >= n_eff - 1);
    if (k >= 2 * d) begin
      p    = k - d;
      mean = window_mean(p, d, none_kept);
      // first full window also stands in for the head positions
      if (p == d) begin
        for (q = 0; q < d; q++)
          add_expected(smooth_result_t'{mean, IDX_W'(q), none_kept, 1'b0});
      end
      add_expected(smooth_result_t'{mean, IDX_W'(p), none_kept, 1'b0});
      if (fin) begin
        for (q = 1; q <= d; q++)
          add_expected(smooth_result_t'{mean, IDX_W'(p + q), none_kept, q == d});
      end
    end
    sample_idx = fin ? '0 : sample_idx + 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_result_t got;
    smooth_result_t want;
    int j;
    if (!rst_ni) begin
      half_window  = mmas_pkg::HALF_WINDOW_RST;
      jump_limit   = mmas_pkg::JUMP_LIMIT_RST;
      protect_low  = mmas_pkg::PROTECT_LOW_RST;
      protect_high = mmas_pkg::PROTECT_HIGH_RST;
      sat_level    = mmas_pkg::SAT_LEVEL_RST;
      sat_start    = mmas_pkg::SAT_START_RST;
      sample_count = mmas_pkg::SAMPLE_COUNT_RST;
      for (j = 0; j < STORE_DEPTH; j++) sample_store[j] = '0;
      sample_idx = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mmas_pkg::CFG_HALF_WINDOW:  half_window  = cfg_data_i[HW_W-1:0];
          mmas_pkg::CFG_JUMP_LIMIT:   jump_limit   = cfg_data_i;
          mmas_pkg::CFG_PROTECT_LOW:  protect_low  = cfg_data_i[IDX_W-1:0];
          mmas_pkg::CFG_PROTECT_HIGH: protect_high = cfg_data_i[IDX_W-1:0];
          mmas_pkg::CFG_SAT_LEVEL:    sat_level    = cfg_data_i;
          mmas_pkg::CFG_SAT_START:    sat_start    = cfg_data_i[IDX_W-1:0];
          mmas_pkg::CFG_SAMPLE_COUNT: sample_count = cfg_data_i[IDX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = smooth_result_t'{smoothed_i, position_i, empty_window_i, last_i};
        if (expected_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result (smoothed/position/empty/last): %0d/%0d/%0b/%0b",
                     got.smoothed, got.position, got.empty_window, got.is_last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_REPORTS)
              $display({"mismatch (smoothed/position/empty/last): ",
                        "want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b"},
                       want.smoothed, want.position, want.empty_window, want.is_last,
                       got.smoothed, got.position, got.empty_window, got.is_last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) release_results(sample_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

// ===== sim/masked_moving_average_smoother_test.sv =====
// testbench top for the masked moving-average smoother: clock, reset, stimulus and verdict
module masked_moving_average_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_IDX_W       = mmas_pkg::CFG_IDX_W;
  localparam int LIM_W           = mmas_pkg::LIM_W;
  localparam int IDX_W           = mmas_pkg::IDX_W;
  localparam int SMP_W           = mmas_pkg::SMP_W;
  localparam int MAX_HALF_WINDOW = mmas_pkg::MAX_HALF_WINDOW;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_CYCLES     = 500;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int NUM_REGS        = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [LIM_W-1:0]     LIM_MAX    = '1;
  localparam logic [IDX_W-1:0]     IDX_MAX    = '1;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [LIM_W-1:0]        cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic signed [SMP_W-1:0] sample_i    = '0;
  logic                    out_ready_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [SMP_W-1:0] smoothed_o;
  logic [IDX_W-1:0]        position_o;
  logic                    empty_window_o;
  logic                    last_o;
  int                      fail_count;
  int                      pending;

  int               send_idle  = 6;
  int               recv_idle  = 45;
  int               hold_asks  = 0;
  int               hold_seen  = 0;
  int               hold_left  = 0;
  int               cycles     = 0;
  int               items_sent = 0;
  int               base       = 0;
  int               spread     = 10;
  logic [LIM_W-1:0] regs [NUM_REGS];

  masked_moving_average_smoother dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .smoothed_o     (smoothed_o),
    .position_o     (position_o),
    .empty_window_o (empty_window_o),
    .last_o         (last_o)
  );

  mmas_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .smoothed_i     (smoothed_o),
    .position_i     (position_o),
    .empty_window_i (empty_window_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen   <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [SMP_W-1:0] draw_sample();
    int pick;
    int offset;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom();
    if (pick < 18) begin
      // spike beyond the normal spread of samples
      offset = spread + int'($urandom_range(60, 1));
      if ($urandom_range(1)) offset = -offset;
      return base + offset;
    end
    if (pick < 24) return regs[mmas_pkg::CFG_SAT_LEVEL] + $urandom_range(500, 1);
    return base + int'($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_regs();
    int r;
    for (r = 0; r < NUM_REGS; r++) write_reg(CFG_IDX_W'(r), regs[r]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SMP_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // drain every expected result, then give an item that released nothing time to finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_waveform(input bit burst, input bit hold);
    int n;
    int hw;
    int cut;
    if (burst) begin
      hw = $urandom_range(MAX_HALF_WINDOW, 17);
      n  = 2 * hw + 1;
    end else begin
      hw = ($urandom_range(7) == 0) ? $urandom_range(63, MAX_HALF_WINDOW + 1)
                                    : $urandom_range(4, 0);
      n  = $urandom_range(30, 3);
    end
    base   = $urandom_range(3000);
    spread = $urandom_range(40, 2);
    regs[mmas_pkg::CFG_HALF_WINDOW]  = LIM_W'(hw);
    regs[mmas_pkg::CFG_SAMPLE_COUNT] = LIM_W'(n);
    case ($urandom_range(7))
      0:       regs[mmas_pkg::CFG_JUMP_LIMIT] = '0;
      1:       regs[mmas_pkg::CFG_JUMP_LIMIT] = LIM_MAX;
      default: regs[mmas_pkg::CFG_JUMP_LIMIT] = LIM_W'($urandom_range(40, 2));
    endcase
    regs[mmas_pkg::CFG_PROTECT_LOW]  = LIM_W'($urandom_range(n));
    regs[mmas_pkg::CFG_PROTECT_HIGH] = ($urandom_range(7) == 0) ? LIM_W'(IDX_MAX)
                                                                : LIM_W'($urandom_range(n));
    case ($urandom_range(7))
      0:       regs[mmas_pkg::CFG_SAT_LEVEL] = '0;
      1:       regs[mmas_pkg::CFG_SAT_LEVEL] = LIM_MAX;
      default: regs[mmas_pkg::CFG_SAT_LEVEL] = LIM_W'(base + int'($urandom_range(200, 20)));
    endcase
    case ($urandom_range(7))
      0:       regs[mmas_pkg::CFG_SAT_START] = '0;
      1:       regs[mmas_pkg::CFG_SAT_START] = LIM_W'(IDX_MAX);
      default: regs[mmas_pkg::CFG_SAT_START] = LIM_W'($urandom_range(n));
    endcase
    load_regs();
    if (hold) hold_asks <= hold_asks + 1;
    if (!burst && n >= 8 && $urandom_range(7) == 0) begin
      // cut the waveform short: the next sample becomes the final one
      cut = $urandom_range(n - 2, 2);
      repeat (cut) send_sample(draw_sample());
      wait_idle();
      regs[mmas_pkg::CFG_SAMPLE_COUNT] = LIM_W'($urandom_range(cut + 1, 3));
      regs[mmas_pkg::CFG_HALF_WINDOW]  = LIM_W'($urandom_range(6));
      load_regs();
      send_sample(draw_sample());
    end else begin
      repeat (n) send_sample(draw_sample());
    end
    wait_idle();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input bit with_hold);
    int phase_start;
    send_idle   = s_idle;
    recv_idle  <= r_idle;
    phase_start = items_sent;
    random_waveform(1'b1, with_hold);
    while (items_sent - phase_start < ITEMS_PER_PHASE) random_waveform(1'b0, 1'b0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sample extremes, shortest waveform, zero half window, widest limits
    regs[mmas_pkg::CFG_HALF_WINDOW]  = '0;
    regs[mmas_pkg::CFG_JUMP_LIMIT]   = LIM_MAX;
    regs[mmas_pkg::CFG_PROTECT_LOW]  = '0;
    regs[mmas_pkg::CFG_PROTECT_HIGH] = LIM_W'(IDX_MAX);
    regs[mmas_pkg::CFG_SAT_LEVEL]    = LIM_MAX;
    regs[mmas_pkg::CFG_SAT_START]    = LIM_W'(IDX_MAX);
    regs[mmas_pkg::CFG_SAMPLE_COUNT] = '0;
    write_reg(CFG_UNUSED, LIM_MAX);
    load_regs();
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(-1);
    wait_idle();

    // oversized half window clipped to the waveform, every sample rejected
    regs[mmas_pkg::CFG_HALF_WINDOW]  = LIM_W'(63);
    regs[mmas_pkg::CFG_JUMP_LIMIT]   = '0;
    regs[mmas_pkg::CFG_PROTECT_LOW]  = LIM_W'(IDX_MAX);
    regs[mmas_pkg::CFG_PROTECT_HIGH] = '0;
    regs[mmas_pkg::CFG_SAT_LEVEL]    = '0;
    regs[mmas_pkg::CFG_SAT_START]    = '0;
    regs[mmas_pkg::CFG_SAMPLE_COUNT] = LIM_W'(5);
    load_regs();
    send_sample(5);
    send_sample(-3);
    send_sample(7);
    send_sample(100);
    send_sample(-50);
    wait_idle();

    // longest waveform cut short by a mid-waveform rewrite of window and length
    regs[mmas_pkg::CFG_HALF_WINDOW]  = LIM_W'(MAX_HALF_WINDOW);
    regs[mmas_pkg::CFG_JUMP_LIMIT]   = LIM_W'(20);
    regs[mmas_pkg::CFG_PROTECT_LOW]  = LIM_W'(3);
    regs[mmas_pkg::CFG_PROTECT_HIGH] = LIM_W'(5);
    regs[mmas_pkg::CFG_SAT_LEVEL]    = LIM_W'(1000);
    regs[mmas_pkg::CFG_SAT_START]    = LIM_W'(8);
    regs[mmas_pkg::CFG_SAMPLE_COUNT] = LIM_W'(IDX_MAX);
    base   = 900;
    spread = 15;
    load_regs();
    repeat (12) send_sample(draw_sample());
    wait_idle();
    regs[mmas_pkg::CFG_HALF_WINDOW]  = LIM_W'(5);
    regs[mmas_pkg::CFG_SAMPLE_COUNT] = LIM_W'(5);
    load_regs();
    send_sample(draw_sample());
    wait_idle();

    run_phase(6, 45, 1'b1);
    run_phase(45, 6, 1'b0);
    run_phase(0, 0, 1'b0);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mmas_pkg.sv
design/masked_moving_average_smoother.sv
sim/mmas_checker.sv
sim/masked_moving_average_smoother_test.sv
